@@ design/hshtw_pkg.sv @@
// shared types and constants of the hashed timer wheel
`timescale 1ns / 1ps
`default_nettype none
package hshtw_pkg;

    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_DESTROY = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [6:0] LINK_NONE  = 7'h7F;

    typedef enum logic [10:0] {
        ST_CLEAR   = 11'b000_0000_0001,
        ST_IDLE    = 11'b000_0000_0010,
        ST_D_WRITE = 11'b000_0000_0100,
        ST_L_MOD   = 11'b000_0000_1000,
        ST_L_READ  = 11'b000_0001_0000,
        ST_L_WRITE = 11'b000_0010_0000,
        ST_T_HEAD  = 11'b000_0100_0000,
        ST_T_STEP  = 11'b000_1000_0000,
        ST_T_EVAL  = 11'b001_0000_0000,
        ST_T_FIN   = 11'b010_0000_0000,
        ST_SPARE   = 11'b100_0000_0000
    } state_t;

endpackage
`default_nettype wire

@@ design/hashed_timer_wheel_core.sv @@
// hashed timer wheel: slot lists, timer tables and the operation sequencer
`timescale 1ns / 1ps
`default_nettype none
// Hashed timing wheel over NUM_TIMERS timers and WHEEL_SLOTS slot lists, kept in
// synchronous memories and worked on by one sequencer, one beat at a time.
// After reset a clearing pass empties the slot heads before the first beat is
// taken. Stop, destroy and init are done in idle, with an unlink step when the
// timer is armed; a start with a finite delay then arms the timer, reducing the
// delay modulo WHEEL_SLOTS by a reciprocal multiplication and then linking it.
// A tick reads the slot head, walks the list entry by entry, re-arms each periodic
// timer that fires and is not destroyed, and waits while the result side stalls;
// results come out in list order, the last one marked.
module hashed_timer_wheel_core #(
    parameter int WHEEL_SLOTS = 64,
    parameter int NUM_TIMERS  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [5:0]  timer_id,
    input  wire logic [31:0] delay,
    input  wire logic        delay_infinite,
    input  wire logic [31:0] period,
    input  wire logic        period_infinite,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       fired_timer,
    output logic             last_fired
);

    localparam int TIDW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SLOTW = $clog2(WHEEL_SLOTS);
    localparam logic [6:0] NT7 = 7'(NUM_TIMERS);
    localparam logic [SLOTW:0] WS = (SLOTW + 1)'(WHEEL_SLOTS);
    localparam logic [SLOTW:0] WS_LAST = (SLOTW + 1)'(WHEEL_SLOTS - 1);
    localparam logic [31:0] WS32 = 32'(WHEEL_SLOTS);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(WHEEL_SLOTS));

    // memories
    logic [63:0]      expiry_mem [NUM_TIMERS];
    logic [SLOTW-1:0] slot_mem   [NUM_TIMERS];
    logic [6:0]       next_mem   [NUM_TIMERS];
    logic [6:0]       prev_mem   [NUM_TIMERS];
    logic [31:0]      reload_mem [NUM_TIMERS];
    logic [6:0]       head_mem   [WHEEL_SLOTS];

    logic [63:0]      expiry_rd_reg;
    logic [SLOTW-1:0] slot_rd_reg;
    logic [6:0]       next_rd_reg;
    logic [6:0]       prev_rd_reg;
    logic [31:0]      reload_rd_reg;
    logic [6:0]       head_rd_reg;

    logic             t_re;
    logic [TIDW-1:0]  t_ra;
    logic             h_re;
    logic [SLOTW-1:0] h_ra;

    logic             exp_we;
    logic             slot_we;
    logic [SLOTW-1:0] slot_wd;
    logic             next_we;
    logic [TIDW-1:0]  next_wa;
    logic [6:0]       next_wd;
    logic             prev_we;
    logic [TIDW-1:0]  prev_wa;
    logic [6:0]       prev_wd;
    logic             rel_we;
    logic [31:0]      rel_wd;
    logic             head_we;
    logic [SLOTW-1:0] head_wa;
    logic [6:0]       head_wd;

    // control and data registers
    hshtw_pkg::state_t state_reg, state_next;
    logic [63:0]       tick_reg, tick_next;
    logic [SLOTW-1:0]  tick_slot_reg, tick_slot_next;
    logic [SLOTW-1:0]  clr_reg, clr_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [NUM_TIMERS-1:0] killed_reg, killed_next;
    logic [NUM_TIMERS-1:0] periodic_reg, periodic_next;
    logic [2:0]        op_reg, op_next;
    logic              dinf_reg, dinf_next;
    logic [TIDW-1:0]   tid_reg, tid_next;
    logic              tickmode_reg, tickmode_next;
    logic [6:0]        cur_reg, cur_next;
    logic [6:0]        nxt_reg, nxt_next;
    logic [6:0]        steps_reg, steps_next;
    logic [31:0]       mval_reg, mval_next;
    logic              mcnt_reg, mcnt_next;
    logic [31:0]       quot_reg, quot_next;
    logic [SLOTW-1:0]  rem_reg, rem_next;
    logic [63:0]       date_reg, date_next;
    logic [SLOTW-1:0]  nslot_reg, nslot_next;
    logic              pend_reg, pend_next;
    logic [TIDW-1:0]   pend_id_reg, pend_id_next;
    logic              out_valid_reg, out_valid_next;
    logic [5:0]        out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              out_free;
    logic [63:0]       quot_prod;
    logic [31:0]       mod_diff;
    logic [SLOTW:0]    slot_sum;
    logic [SLOTW-1:0]  slot_new;
    logic [TIDW-1:0]   in_tid;
    logic              in_id_ok;
    logic              head_ok;
    logic              cur_ok;

    assign in_stall    = (state_reg != hshtw_pkg::ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign fired_timer = out_id_reg;
    assign last_fired  = out_last_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_tid      = timer_id[TIDW-1:0];
    assign in_id_ok    = ({1'b0, timer_id} < NT7);
    assign head_ok     = (head_rd_reg < NT7);
    assign cur_ok      = (cur_reg < NT7) && (steps_reg < NT7);

    // quotient estimate by reciprocal, low by at most one
    assign quot_prod = {32'd0, mval_reg} * {32'd0, RECIP};
    assign mod_diff  = mval_reg - quot_reg * WS32;
    assign slot_sum  = {1'b0, rem_reg} + {1'b0, tick_slot_reg};
    assign slot_new  = (slot_sum >= WS) ? SLOTW'(slot_sum - WS) : slot_sum[SLOTW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        tick_slot_next = tick_slot_reg;
        clr_next       = clr_reg;
        armed_next     = armed_reg;
        killed_next    = killed_reg;
        periodic_next  = periodic_reg;
        op_next        = op_reg;
        dinf_next      = dinf_reg;
        tid_next       = tid_reg;
        tickmode_next  = tickmode_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        steps_next     = steps_reg;
        mval_next      = mval_reg;
        mcnt_next      = mcnt_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        date_next      = date_reg;
        nslot_next     = nslot_reg;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;

        t_re    = 1'b0;
        t_ra    = tid_reg;
        h_re    = 1'b0;
        h_ra    = tick_slot_reg;
        exp_we  = 1'b0;
        slot_we = 1'b0;
        slot_wd = slot_new;
        next_we = 1'b0;
        next_wa = tid_reg;
        next_wd = next_rd_reg;
        prev_we = 1'b0;
        prev_wa = tid_reg;
        prev_wd = prev_rd_reg;
        rel_we  = 1'b0;
        rel_wd  = 32'd0;
        head_we = 1'b0;
        head_wa = slot_rd_reg;
        head_wd = next_rd_reg;

        case (state_reg)
            hshtw_pkg::ST_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = clr_reg;
                head_wd = hshtw_pkg::LINK_NONE;
                clr_next = clr_reg + 1'b1;
                if ({1'b0, clr_reg} == WS_LAST)
                begin
                    state_next = hshtw_pkg::ST_IDLE;
                end
            end
            hshtw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode;
                    dinf_next = delay_infinite;
                    tid_next  = in_tid;
                    tickmode_next = 1'b0;
                    mval_next = delay;
                    mcnt_next = 1'b0;
                    rem_next  = '0;
                    date_next = tick_reg + {32'd0, delay};
                    if (opcode == hshtw_pkg::OP_TICK)
                    begin
                        tickmode_next = 1'b1;
                        steps_next    = '0;
                        h_re          = 1'b1;
                        h_ra          = tick_slot_reg;
                        state_next    = hshtw_pkg::ST_T_HEAD;
                    end
                    else if (in_id_ok && opcode <= hshtw_pkg::OP_DESTROY)
                    begin
                        case (opcode)
                            hshtw_pkg::OP_INIT:
                            begin
                                killed_next[in_tid]   = 1'b0;
                                periodic_next[in_tid] = 1'b1;
                                rel_we = 1'b1;
                                rel_wd = 32'd0;
                            end
                            hshtw_pkg::OP_START:
                            begin
                                periodic_next[in_tid] = !period_infinite;
                                rel_we = 1'b1;
                                rel_wd = period;
                            end
                            hshtw_pkg::OP_DESTROY:
                            begin
                                killed_next[in_tid] = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (armed_reg[in_tid])
                        begin
                            t_re       = 1'b1;
                            t_ra       = in_tid;
                            state_next = hshtw_pkg::ST_D_WRITE;
                        end
                        else if (opcode == hshtw_pkg::OP_START && !delay_infinite)
                        begin
                            state_next = hshtw_pkg::ST_L_MOD;
                        end
                    end
                end
            end
            hshtw_pkg::ST_D_WRITE:
            begin
                // unlink from its slot list
                if (prev_rd_reg < NT7)
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd_reg[TIDW-1:0];
                    next_wd = next_rd_reg;
                end
                else
                begin
                    head_we = 1'b1;
                    head_wa = slot_rd_reg;
                    head_wd = next_rd_reg;
                end
                if (next_rd_reg < NT7)
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd_reg[TIDW-1:0];
                    prev_wd = prev_rd_reg;
                end
                armed_next[tid_reg] = 1'b0;
                if (op_reg == hshtw_pkg::OP_START && !dinf_reg)
                begin
                    state_next = hshtw_pkg::ST_L_MOD;
                end
                else
                begin
                    state_next = hshtw_pkg::ST_IDLE;
                end
            end
            hshtw_pkg::ST_L_MOD:
            begin
                if (!mcnt_reg)
                begin
                    quot_next = quot_prod[63:32];
                    mcnt_next = 1'b1;
                end
                else
                begin
                    rem_next   = (mod_diff >= WS32) ? SLOTW'(mod_diff - WS32)
                                                    : mod_diff[SLOTW-1:0];
                    state_next = hshtw_pkg::ST_L_READ;
                end
            end
            hshtw_pkg::ST_L_READ:
            begin
                exp_we  = 1'b1;
                slot_we = 1'b1;
                slot_wd = slot_new;
                prev_we = 1'b1;
                prev_wa = tid_reg;
                prev_wd = hshtw_pkg::LINK_NONE;
                h_re    = 1'b1;
                h_ra    = slot_new;
                nslot_next = slot_new;
                state_next = hshtw_pkg::ST_L_WRITE;
            end
            hshtw_pkg::ST_L_WRITE:
            begin
                // prepend to the slot list
                next_we = 1'b1;
                next_wa = tid_reg;
                next_wd = head_rd_reg;
                head_we = 1'b1;
                head_wa = nslot_reg;
                head_wd = 7'(tid_reg);
                if (head_ok)
                begin
                    prev_we = 1'b1;
                    prev_wa = head_rd_reg[TIDW-1:0];
                    prev_wd = 7'(tid_reg);
                end
                armed_next[tid_reg] = 1'b1;
                if (tickmode_reg)
                begin
                    cur_next   = nxt_reg;
                    state_next = hshtw_pkg::ST_T_STEP;
                end
                else
                begin
                    state_next = hshtw_pkg::ST_IDLE;
                end
            end
            hshtw_pkg::ST_T_HEAD:
            begin
                cur_next   = head_rd_reg;
                state_next = hshtw_pkg::ST_T_STEP;
            end
            hshtw_pkg::ST_T_STEP:
            begin
                if (cur_ok)
                begin
                    t_re       = 1'b1;
                    t_ra       = cur_reg[TIDW-1:0];
                    tid_next   = cur_reg[TIDW-1:0];
                    steps_next = steps_reg + 1'b1;
                    state_next = hshtw_pkg::ST_T_EVAL;
                end
                else
                begin
                    state_next = hshtw_pkg::ST_T_FIN;
                end
            end
            hshtw_pkg::ST_T_EVAL:
            begin
                if (expiry_rd_reg > tick_reg)
                begin
                    cur_next   = next_rd_reg;
                    state_next = hshtw_pkg::ST_T_STEP;
                end
                else if (!pend_reg || out_free)
                begin
                    // the held result is not the last one of this tick
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = 6'(pend_id_reg);
                        out_last_next  = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = tid_reg;
                    if (prev_rd_reg < NT7)
                    begin
                        next_we = 1'b1;
                        next_wa = prev_rd_reg[TIDW-1:0];
                        next_wd = next_rd_reg;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wa = slot_rd_reg;
                        head_wd = next_rd_reg;
                    end
                    if (next_rd_reg < NT7)
                    begin
                        prev_we = 1'b1;
                        prev_wa = next_rd_reg[TIDW-1:0];
                        prev_wd = prev_rd_reg;
                    end
                    armed_next[tid_reg] = 1'b0;
                    nxt_next = next_rd_reg;
                    if (!killed_reg[tid_reg] && periodic_reg[tid_reg])
                    begin
                        mval_next  = reload_rd_reg;
                        mcnt_next  = 1'b0;
                        rem_next   = '0;
                        date_next  = tick_reg + {32'd0, reload_rd_reg};
                        state_next = hshtw_pkg::ST_L_MOD;
                    end
                    else
                    begin
                        cur_next   = next_rd_reg;
                        state_next = hshtw_pkg::ST_T_STEP;
                    end
                end
            end
            hshtw_pkg::ST_T_FIN:
            begin
                if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = 6'(pend_id_reg);
                        out_last_next  = 1'b1;
                    end
                    pend_next = 1'b0;
                    tick_next = tick_reg + 64'd1;
                    if ({1'b0, tick_slot_reg} == WS_LAST)
                    begin
                        tick_slot_next = '0;
                    end
                    else
                    begin
                        tick_slot_next = tick_slot_reg + 1'b1;
                    end
                    state_next = hshtw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hshtw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hshtw_pkg::ST_CLEAR;
            tick_reg      <= '0;
            tick_slot_reg <= '0;
            clr_reg       <= '0;
            armed_reg     <= '0;
            killed_reg    <= '0;
            periodic_reg  <= '1;
            tickmode_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            tick_slot_reg <= tick_slot_next;
            clr_reg       <= clr_next;
            armed_reg     <= armed_next;
            killed_reg    <= killed_next;
            periodic_reg  <= periodic_next;
            tickmode_reg  <= tickmode_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        dinf_reg     <= dinf_next;
        tid_reg      <= tid_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        steps_reg    <= steps_next;
        mval_reg     <= mval_next;
        mcnt_reg     <= mcnt_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        date_reg     <= date_next;
        nslot_reg    <= nslot_next;
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    // timer tables, all read at one address
    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            expiry_mem[tid_reg] <= date_reg;
        end
        if (t_re)
        begin
            expiry_rd_reg <= expiry_mem[t_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[tid_reg] <= slot_wd;
        end
        if (t_re)
        begin
            slot_rd_reg <= slot_mem[t_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (t_re)
        begin
            next_rd_reg <= next_mem[t_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (t_re)
        begin
            prev_rd_reg <= prev_mem[t_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rel_we)
        begin
            reload_mem[in_tid] <= rel_wd;
        end
        if (t_re)
        begin
            reload_rd_reg <= reload_mem[t_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (h_re)
        begin
            head_rd_reg <= head_mem[h_ra];
        end
    end

endmodule
`default_nettype wire

@@ sim/tb_hashed_timer_wheel_core.sv @@
// self-checking testbench of the hashed timer wheel core
`timescale 1ns / 1ps
module tb_hashed_timer_wheel_core;

    localparam int SLOTS      = 64;
    localparam int TIMERS     = 64;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_WAIT = 2500;
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = hshtw_pkg::OP_INIT;
    logic [5:0]  timer_id = '0;
    logic [31:0] delay = '0;
    logic        delay_infinite = 1'b0;
    logic [31:0] period = '0;
    logic        period_infinite = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  fired_timer;
    logic        last_fired;

    hashed_timer_wheel_core #(.WHEEL_SLOTS(SLOTS), .NUM_TIMERS(TIMERS)) dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .timer_id(timer_id), .delay(delay),
        .delay_infinite(delay_infinite), .period(period),
        .period_infinite(period_infinite), .out_valid(out_valid),
        .out_stall(out_stall), .fired_timer(fired_timer), .last_fired(last_fired)
    );

    always #2 clk = ~clk;

    // shadow copy of the wheel
    logic [63:0] now_tick;
    logic [63:0] due_date  [TIMERS];
    logic [31:0] interval  [TIMERS];
    logic        periodic  [TIMERS];
    logic        armed     [TIMERS];
    logic        killed    [TIMERS];
    logic [6:0]  head      [SLOTS];
    logic [6:0]  nxt_link  [TIMERS];
    logic [6:0]  prv_link  [TIMERS];

    logic [6:0]  fired_q[$];   // {timer, last}
    int          fails = 0;
    int          beats_sent = 0;
    int          fires_seen = 0;
    int          ticks_sent = 0;
    bit          no_gaps = 1'b0;
    bit          quiet_out = 1'b0;
    int          ostall_cnt = 0;
    int          idle_cycles = 0;

    function automatic void wheel_link(int t);
        int s;
        s = int'(due_date[t] % SLOTS);
        nxt_link[t] = head[s];
        prv_link[t] = hshtw_pkg::LINK_NONE;
        if (head[s] < TIMERS)
            prv_link[head[s]] = 7'(t);
        head[s] = 7'(t);
        armed[t] = 1'b1;
    endfunction

    function automatic void wheel_unlink(int t);
        int s;
        s = int'(due_date[t] % SLOTS);
        if (prv_link[t] < TIMERS)
            nxt_link[prv_link[t]] = nxt_link[t];
        else
            head[s] = nxt_link[t];
        if (nxt_link[t] < TIMERS)
            prv_link[nxt_link[t]] = prv_link[t];
        armed[t] = 1'b0;
    endfunction

    function automatic void wheel_reset();
        now_tick = '0;
        for (int i = 0; i < TIMERS; i++)
        begin
            due_date[i] = '0;
            interval[i] = '0;
            periodic[i] = 1'b1;
            armed[i]    = 1'b0;
            killed[i]   = 1'b0;
            nxt_link[i] = '0;
            prv_link[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
            head[i] = hshtw_pkg::LINK_NONE;
    endfunction

    function automatic void wheel_predict(logic [2:0] op, logic [5:0] id, logic [31:0] dly,
                                          logic dinf, logic [31:0] per, logic pinf);
        logic [6:0] cur;
        logic [6:0] nx;
        int         steps;
        int         hits[$];
        if (op == hshtw_pkg::OP_TICK)
        begin
            cur = head[int'(now_tick % SLOTS)];
            steps = 0;
            while (cur < TIMERS && steps < TIMERS)
            begin
                nx = nxt_link[cur];
                steps++;
                if (due_date[cur] <= now_tick)
                begin
                    wheel_unlink(cur);
                    hits.push_back(cur);
                    if (!killed[cur] && periodic[cur])
                    begin
                        due_date[cur] = now_tick + 64'(interval[cur]);
                        wheel_link(cur);
                    end
                end
                cur = nx;
            end
            foreach (hits[i])
                fired_q.push_back({6'(hits[i]), i == hits.size() - 1});
            now_tick = now_tick + 1;
        end
        else if (op == hshtw_pkg::OP_INIT)
        begin
            if (armed[id]) wheel_unlink(id);
            killed[id] = 1'b0;
            periodic[id] = 1'b1;
            interval[id] = '0;
        end
        else if (op == hshtw_pkg::OP_START)
        begin
            interval[id] = per;
            periodic[id] = !pinf;
            if (armed[id]) wheel_unlink(id);
            if (!dinf)
            begin
                due_date[id] = now_tick + 64'(dly);
                wheel_link(id);
            end
        end
        else if (op == hshtw_pkg::OP_STOP || op == hshtw_pkg::OP_DESTROY)
        begin
            if (armed[id]) wheel_unlink(id);
            if (op == hshtw_pkg::OP_DESTROY) killed[id] = 1'b1;
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(logic [2:0] op, logic [5:0] id, logic [31:0] dly,
                             logic dinf, logic [31:0] per, logic pinf);
        int gap;
        opcode          <= op;
        timer_id        <= id;
        delay           <= dly;
        delay_infinite  <= dinf;
        period          <= per;
        period_infinite <= pinf;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        wheel_predict(op, id, dly, dinf, per, pinf);
        beats_sent++;
        if (op == hshtw_pkg::OP_TICK) ticks_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (fired_q.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_tick();
        send_beat(hshtw_pkg::OP_TICK, 6'($urandom), $urandom, 1'($urandom), $urandom,
                  1'($urandom));
    endtask

    task automatic test_directed();
        // due now, one-shot
        send_beat(hshtw_pkg::OP_START, 6'd0, 32'd0, 1'b0, 32'd0, 1'b1);
        send_beat(hshtw_pkg::OP_START, 6'd63, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        // periodic, interval zero
        send_beat(hshtw_pkg::OP_START, 6'd1, 32'd0, 1'b0, 32'd0, 1'b0);
        // shares slot, not yet due
        send_beat(hshtw_pkg::OP_START, 6'd2, 32'd64, 1'b0, 32'd1, 1'b0);
        send_tick();
        send_beat(hshtw_pkg::OP_START, 6'd3, 32'd1, 1'b0, 32'd2, 1'b0);
        send_beat(hshtw_pkg::OP_START, 6'd4, 32'd1, 1'b0, 32'd0, 1'b1);
        send_tick();
        // stop of idle timer
        send_beat(hshtw_pkg::OP_STOP, 6'd5, 32'd0, 1'b0, 32'd0, 1'b0);
        // killed while idle, then started with the mark kept
        send_beat(hshtw_pkg::OP_DESTROY, 6'd6, 32'd0, 1'b0, 32'd0, 1'b0);
        send_beat(hshtw_pkg::OP_START, 6'd6, 32'd1, 1'b0, 32'd1, 1'b0);
        // disarm only
        send_beat(hshtw_pkg::OP_START, 6'd3, 32'd5, 1'b1, 32'd3, 1'b0);
        // init of armed timer
        send_beat(hshtw_pkg::OP_INIT, 6'd63, 32'd0, 1'b0, 32'd0, 1'b0);
        send_beat(OP_SPARE_LO, 6'd7, 32'd0, 1'b0, 32'd0, 1'b0);
        send_beat(OP_SPARE_MID, 6'd8, 32'd0, 1'b0, 32'd0, 1'b0);
        send_beat(OP_SPARE_HI, 6'd9, 32'd0, 1'b0, 32'd0, 1'b0);
        send_tick();
        send_beat(hshtw_pkg::OP_DESTROY, 6'd2, 32'd0, 1'b0, 32'd0, 1'b0);
        send_tick();
        send_tick();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
                send_tick();
            else if (r < 70)
                send_beat(hshtw_pkg::OP_START, 6'($urandom), $urandom_range(0, 12), 1'b0,
                          $urandom_range(0, 6), 1'($urandom_range(0, 2) == 0));
            else if (r < 74)
                send_beat(hshtw_pkg::OP_START, 6'($urandom), $urandom, 1'($urandom),
                          $urandom, 1'($urandom));
            else if (r < 84)
                send_beat(hshtw_pkg::OP_STOP, 6'($urandom), $urandom, 1'($urandom),
                          $urandom, 1'($urandom));
            else if (r < 91)
                send_beat(hshtw_pkg::OP_DESTROY, 6'($urandom), $urandom, 1'($urandom),
                          $urandom, 1'($urandom));
            else if (r < 97)
                send_beat(hshtw_pkg::OP_INIT, 6'($urandom), $urandom, 1'($urandom),
                          $urandom, 1'($urandom));
            else
                send_beat(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 6'($urandom),
                          $urandom, 1'($urandom), $urandom, 1'($urandom));
        end
    endtask

    // hold the sender until the wheel has emptied its output, then send 20 random beats
    task automatic test_pause();
        wait_drained();
        test_random(20);
    endtask

    // output side back-pressure, with quiet stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) quiet_out <= ~quiet_out;
        if (ostall_cnt > 0)
        begin
            ostall_cnt <= ostall_cnt - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet_out && $urandom_range(0, 99) < 25)
        begin
            ostall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // compare each fired-timer beat with the oldest prediction
    always @(posedge clk)
    begin
        logic [6:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            fires_seen++;
            if (fired_q.size() == 0)
            begin
                $error("unexpected result beat: fired_timer %0d last_fired %0d",
                       fired_timer, last_fired);
                fails++;
            end
            else
            begin
                want = fired_q.pop_front();
                if (fired_timer !== want[6:1])
                begin
                    $error("fired_timer: expected %0d, got %0d", want[6:1], fired_timer);
                    fails++;
                end
                if (last_fired !== want[0])
                begin
                    $error("last_fired: expected %0d, got %0d", want[0], last_fired);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        wheel_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(60);
        test_pause();
        test_random(60);
        wait_drained();
        if (fired_q.size() != 0)
        begin
            $error("%0d predicted expiries never arrived", fired_q.size());
            fails++;
        end
        $display("covered %0d beats, %0d of them ticks, and %0d expiries", beats_sent,
                 ticks_sent, fires_seen);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
